>>> hw/rtl/bltr_pkg.sv
// shared types and constants of the button event and long-press tracker
package bltr_pkg;

  localparam int BUTTONS = 8;
  localparam int MASK_W = 8;
  localparam int KIND_W = 3;
  localparam int TIME_W = 32;

  localparam logic [MASK_W-1:0] BUTTON_MASK = MASK_W'((1 << BUTTONS) - 1);
  localparam logic [TIME_W-1:0] LONG_PRESS_RESET = TIME_W'(1000);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK         = 3'd0,
    KIND_INIT         = 3'd1,
    KIND_TAKE_PRESS   = 3'd2,
    KIND_TAKE_RELEASE = 3'd3,
    KIND_TAKE_LONG    = 3'd4,
    KIND_READ_MASK    = 3'd5
  } kind_t;

  // shared by every button lane for the word being processed
  typedef struct packed {
    logic              tick;
    logic              init;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] long_press_ms;
  } lane_ctrl_t;

endpackage

>>> hw/rtl/bltr_item_if.sv
// input channel: tick, init and read requests
interface bltr_item_if;
  logic                          valid;
  logic                          ready;
  logic [bltr_pkg::KIND_W-1:0]   kind;
  logic [bltr_pkg::MASK_W-1:0]   key_mask;
  logic [bltr_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, kind, key_mask, now_ms, input ready);
  modport sink (input valid, kind, key_mask, now_ms, output ready);
endinterface

>>> hw/rtl/bltr_result_if.sv
// output channel: one read value per request
interface bltr_result_if;
  logic                        valid;
  logic                        ready;
  logic [bltr_pkg::MASK_W-1:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

>>> hw/rtl/bltr_lane.sv
// one button lane: press time stamp and long-press threshold check
module bltr_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  bltr_pkg::lane_ctrl_t ctrl,
  input  logic                 rise,
  input  logic                 held_next,
  input  logic                 armed,
  output logic                 long_hit
);
  import bltr_pkg::*;

  logic [TIME_W-1:0] press_start;
  logic [TIME_W-1:0] hold_time;

  // a fresh press has held for zero time on this tick
  assign hold_time = rise ? '0 : (ctrl.now_ms - press_start);
  assign long_hit  = ctrl.tick && held_next && armed && (hold_time >= ctrl.long_press_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      press_start <= '0;
    end else if (fire && ((ctrl.tick && rise) || ctrl.init)) begin
      press_start <= ctrl.now_ms;
    end
  end

endmodule

>>> hw/rtl/button_event_long_press_tracker_unit.sv
// button event and long-press tracker: top level
// Tracks up to BUTTONS debounced buttons. A tick word carries the new key mask and a
// wrapping 32-bit millisecond time; rising edges set sticky pressed bits and stamp the
// press time, falling edges set sticky released bits and re-arm long-press detection,
// and a held button whose hold time (now_ms minus press time, modulo 2^32) reaches
// long_press_ms raises its sticky long-press bit once per press. An init word loads the
// mask, clears every event and stamps all press times (buttons held at init give no
// pressed event). Take words return one event mask and clear it; read mask returns the
// current mask. Every word gives exactly one result word, zero for tick, init and
// unused kinds. Throughput is one word per clock while result.ready keeps up; a held
// result stalls the input register. The accepting edge loads the input register, and
// the result register loads from it when the stage moves on. The per-cycle path is set
// by the eight parallel 32-bit subtract and compare lanes of the long-press check.
// long_press_ms resets to 1000 and is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while idle, the block itself does not enforce this.
module button_event_long_press_tracker_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bltr_pkg::TIME_W-1:0]   cfg_wr_data,
  bltr_item_if.sink                     item,
  bltr_result_if.source                 result
);
  import bltr_pkg::*;

  // configuration
  logic [TIME_W-1:0] long_press_ms;

  // input register stage
  logic              stage_valid;
  kind_t             stage_kind;
  logic [MASK_W-1:0] stage_mask;
  logic [TIME_W-1:0] stage_now;

  // result register
  logic              out_valid;
  logic [MASK_W-1:0] out_value;

  // tracker state
  logic [MASK_W-1:0] held_mask, held_mask_next;
  logic [MASK_W-1:0] press_event_bits, press_event_bits_next;
  logic [MASK_W-1:0] release_event_bits, release_event_bits_next;
  logic [MASK_W-1:0] long_event_bits, long_event_bits_next;
  logic [MASK_W-1:0] long_reported_bits, long_reported_bits_next;

  logic              advance;
  logic              fire;
  logic [MASK_W-1:0] rise, fall, rearmed, long_hit;
  logic [MASK_W-1:0] value;
  lane_ctrl_t        lane_ctrl;

  // the stage moves on whenever the result register is free or being emptied
  assign advance    = !out_valid || result.ready;
  assign fire       = stage_valid && advance;
  assign item.ready = !stage_valid || advance;

  assign result.valid      = out_valid;
  assign result.read_value = out_value;

  // edges against the held mask, and long-press arming after releases
  assign rise    = stage_mask & ~held_mask;
  assign fall    = held_mask & ~stage_mask;
  assign rearmed = long_reported_bits & ~fall;

  assign lane_ctrl.tick          = (stage_kind == KIND_TICK);
  assign lane_ctrl.init          = (stage_kind == KIND_INIT);
  assign lane_ctrl.now_ms        = stage_now;
  assign lane_ctrl.long_press_ms = long_press_ms;

  // one lane per button, unused slots stay quiet
  for (genvar g = 0; g < MASK_W; g++) begin : g_lane
    if (g < BUTTONS) begin : g_used
      bltr_lane u_lane (
        .clk       (clk),
        .rst       (rst),
        .fire      (fire),
        .ctrl      (lane_ctrl),
        .rise      (rise[g]),
        .held_next (stage_mask[g]),
        .armed     (!rearmed[g]),
        .long_hit  (long_hit[g])
      );
    end else begin : g_unused
      assign long_hit[g] = 1'b0;
    end
  end

  // state update and result value for the word in the stage
  always_comb begin
    held_mask_next          = held_mask;
    press_event_bits_next   = press_event_bits;
    release_event_bits_next = release_event_bits;
    long_event_bits_next    = long_event_bits;
    long_reported_bits_next = long_reported_bits;
    value                   = '0;
    case (stage_kind)
      KIND_TICK: begin
        held_mask_next          = stage_mask;
        press_event_bits_next   = press_event_bits | rise;
        release_event_bits_next = release_event_bits | fall;
        long_event_bits_next    = long_event_bits | long_hit;
        long_reported_bits_next = rearmed | long_hit;
      end
      KIND_INIT: begin
        held_mask_next          = stage_mask;
        press_event_bits_next   = '0;
        release_event_bits_next = '0;
        long_event_bits_next    = '0;
        long_reported_bits_next = '0;
      end
      KIND_TAKE_PRESS: begin
        value                 = press_event_bits;
        press_event_bits_next = '0;
      end
      KIND_TAKE_RELEASE: begin
        value                   = release_event_bits;
        release_event_bits_next = '0;
      end
      KIND_TAKE_LONG: begin
        value                = long_event_bits;
        long_event_bits_next = '0;
      end
      KIND_READ_MASK: begin
        value = held_mask;
      end
      default: begin
        value = '0;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_wr_en) begin
      long_press_ms <= cfg_wr_data;
    end
  end

  // input register stage, buttons beyond the configured count are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      stage_kind <= kind_t'(item.kind);
      stage_mask <= item.key_mask & BUTTON_MASK;
      stage_now  <= item.now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_value <= value;
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask          <= '0;
      press_event_bits   <= '0;
      release_event_bits <= '0;
      long_event_bits    <= '0;
      long_reported_bits <= '0;
    end else if (fire) begin
      held_mask          <= held_mask_next;
      press_event_bits   <= press_event_bits_next;
      release_event_bits <= release_event_bits_next;
      long_event_bits    <= long_event_bits_next;
      long_reported_bits <= long_reported_bits_next;
    end
  end

`ifndef SYNTH
  // a reported long press always belongs to a button still held
  a_reported_held: assert property (@(posedge clk) disable iff (rst)
    (long_reported_bits & ~held_mask) == '0)
    else $error("long-press reported for a released button");

  // no state bit for buttons beyond the configured count
  a_unused_buttons: assert property (@(posedge clk) disable iff (rst)
    ((held_mask | press_event_bits | release_event_bits | long_event_bits) & ~BUTTON_MASK) == '0)
    else $error("event bit set for an unused button");

  // tick and init words give a zero result
  a_tick_zero: assert property (@(posedge clk) disable iff (rst)
    fire && (stage_kind == KIND_TICK || stage_kind == KIND_INIT) |=> out_value == '0)
    else $error("non-zero result for tick or init");

  // a stalled stage never takes a new word
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    !(item.ready && stage_valid && !advance))
    else $error("input accepted while stage stalled");

  // a processed word always lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result lost after processing");
`endif

endmodule
